// ===== rtl/core/prsd_pkg.sv =====
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types and constants of the subtitle span decoder: the command word
// passed from the byte parser to the span executor and the code byte fields.
// ----------------------------------------------------------------------------
package prsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned LEN_W   = 14;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned ADDR_W  = 8;

    // output word layout, lowest field first
    localparam int unsigned M_TDATA_W = 56;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    // flag byte: top two bits select the kind of run
    localparam logic [1:0] RUN_SHORT_CLEAR = 2'b00;
    localparam logic [1:0] RUN_LONG_CLEAR  = 2'b01;
    localparam logic [1:0] RUN_SHORT_COLOR = 2'b10;
    localparam logic [1:0] RUN_LONG_COLOR  = 2'b11;

    localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h00;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_RUN,
        CMD_EOL
    } cmd_kind_t;

    // one command from the parser to the executor
    typedef struct packed {
        cmd_kind_t           kind;
        logic [LEN_W-1:0]    run_len;
        logic [BYTE_W-1:0]   color;
        logic [COORD_W-1:0]  row;
        logic                done;
        logic                eod;
    } cmd_t;

endpackage

// ===== rtl/core/prsd_front.sv =====
// ----------------------------------------------------------------------------
// prsd_front
// Byte parser: tracks the code phase, pending run length, row and finished
// flag, and turns each accepted byte into a run, end-of-line or no-op command.
// ----------------------------------------------------------------------------
module prsd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_accept,
    input  logic [prsd_pkg::BYTE_W-1:0]   rle_byte,
    input  logic                          end_of_data,
    input  logic [prsd_pkg::CFG_W-1:0]    image_height,
    output logic                          cmd_push,
    output prsd_pkg::cmd_t                cmd
);
    import prsd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_LOWLEN,
        PH_COLOR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               has_color_reg, has_color_next;
    logic [LEN_W-1:0]   pend_reg, pend_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               finished_reg, finished_next;

    logic               ignore;
    logic [COORD_W-1:0] row_inc;
    logic [LEN_W-1:0]   short_len;
    logic [LEN_W-1:0]   high_len;
    logic [LEN_W-1:0]   merged_len;

    assign ignore     = finished_reg || (row_reg >= image_height);
    assign row_inc    = row_reg + 16'd1;
    assign short_len  = {{(LEN_W-6){1'b0}}, rle_byte[5:0]};
    assign high_len   = {rle_byte[5:0], 8'h00};
    assign merged_len = pend_reg | {{(LEN_W-BYTE_W){1'b0}}, rle_byte};

    // byte classification and next parser state
    always_comb begin
        phase_next     = phase_reg;
        has_color_next = has_color_reg;
        pend_next      = pend_reg;
        row_next       = row_reg;
        finished_next  = finished_reg;
        cmd.kind       = CMD_NOP;
        cmd.run_len    = '0;
        cmd.color      = '0;
        cmd.row        = row_reg;
        cmd.done       = 1'b0;
        cmd.eod        = end_of_data;

        if (!ignore) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (rle_byte != BYTE_ESCAPE) begin
                        cmd.kind    = CMD_RUN;
                        cmd.run_len = {{(LEN_W-1){1'b0}}, 1'b1};
                        cmd.color   = rle_byte;
                    end else begin
                        phase_next = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    phase_next = PH_IDLE;
                    if (rle_byte == BYTE_ESCAPE) begin
                        cmd.kind      = CMD_EOL;
                        cmd.done      = (row_inc >= image_height);
                        row_next      = row_inc;
                        finished_next = (row_inc >= image_height);
                    end else begin
                        case (rle_byte[7:6])
                            RUN_SHORT_CLEAR: begin
                                cmd.kind    = CMD_RUN;
                                cmd.run_len = short_len;
                            end
                            RUN_LONG_CLEAR: begin
                                pend_next      = high_len;
                                has_color_next = 1'b0;
                                phase_next     = PH_LOWLEN;
                            end
                            RUN_SHORT_COLOR: begin
                                pend_next      = short_len;
                                has_color_next = 1'b1;
                                phase_next     = PH_COLOR;
                            end
                            default: begin
                                pend_next      = high_len;
                                has_color_next = 1'b1;
                                phase_next     = PH_LOWLEN;
                            end
                        endcase
                    end
                end
                PH_LOWLEN: begin
                    pend_next = merged_len;
                    if (has_color_reg) begin
                        phase_next = PH_COLOR;
                    end else begin
                        phase_next  = PH_IDLE;
                        cmd.kind    = CMD_RUN;
                        cmd.run_len = merged_len;
                    end
                end
                default: begin
                    phase_next  = PH_IDLE;
                    cmd.kind    = CMD_RUN;
                    cmd.run_len = pend_reg;
                    cmd.color   = rle_byte;
                end
            endcase
        end
    end

    // every word that does something, or ends the object, goes to the queue
    assign cmd_push = byte_accept && ((cmd.kind != CMD_NOP) || end_of_data);

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            has_color_reg <= 1'b0;
            pend_reg      <= '0;
            row_reg       <= '0;
            finished_reg  <= 1'b0;
        end else if (byte_accept) begin
            if (end_of_data) begin
                phase_reg     <= PH_IDLE;
                has_color_reg <= 1'b0;
                pend_reg      <= '0;
                row_reg       <= '0;
                finished_reg  <= 1'b0;
            end else begin
                phase_reg     <= phase_next;
                has_color_reg <= has_color_next;
                pend_reg      <= pend_next;
                row_reg       <= row_next;
                finished_reg  <= finished_next;
            end
        end
    end

endmodule

// ===== rtl/core/prsd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// prsd_cmd_fifo
// Two-entry command queue between the parser and the span executor.
// ----------------------------------------------------------------------------
module prsd_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  prsd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output prsd_pkg::cmd_t head_cmd
);
    import prsd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/prsd_back.sv =====
// ----------------------------------------------------------------------------
// prsd_back
// Span executor: keeps the column, clips each run to the image width and
// drives the registered result word.
// ----------------------------------------------------------------------------
module prsd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [prsd_pkg::CFG_W-1:0]     image_width,
    input  logic                           cmd_valid,
    input  prsd_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [prsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import prsd_pkg::*;

    logic [COORD_W-1:0] column_reg, column_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  color_reg, color_next;
    logic [COORD_W-1:0] start_reg, start_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;

    logic [COORD_W-1:0] room;
    logic [LEN_W-1:0]   span_n;
    logic               emit;

    assign cmd_pop = cmd_valid && (!out_valid_reg || m_tready);

    // pixels left on the line and the clipped run length
    assign room   = (column_reg < image_width) ? (image_width - column_reg) : '0;
    assign span_n = ({2'b00, cmd.run_len} < room) ? cmd.run_len : room[LEN_W-1:0];

    always_comb begin
        emit        = 1'b0;
        column_next = column_reg;
        color_next  = color_reg;
        start_next  = start_reg;
        row_next    = row_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        if (cmd_pop) begin
            case (cmd.kind)
                CMD_RUN: begin
                    if (span_n != '0) begin
                        emit        = 1'b1;
                        color_next  = cmd.color;
                        start_next  = column_reg;
                        row_next    = cmd.row;
                        len_next    = span_n;
                        last_next   = 1'b0;
                        done_next   = 1'b0;
                        column_next = column_reg + {2'b00, span_n};
                    end
                end
                CMD_EOL: begin
                    emit        = 1'b1;
                    color_next  = '0;
                    start_next  = '0;
                    row_next    = cmd.row;
                    len_next    = '0;
                    last_next   = 1'b1;
                    done_next   = cmd.done;
                    column_next = '0;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            if (cmd.eod) begin
                column_next = '0;
            end
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // column and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        color_reg <= color_next;
        start_reg <= start_next;
        row_reg   <= row_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, len_reg, row_reg, start_reg, color_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

// ===== rtl/core/pgs_rle_span_decoder.sv =====
// ----------------------------------------------------------------------------
// pgs_rle_span_decoder
// Decodes a run-length coded subtitle bitmap, one byte per word, into spans
// and end-of-line marks, clipped to the configured image size.
// ----------------------------------------------------------------------------
// An accepted byte's command goes into the two-entry command queue; the
// executor registers its result word. Throughput: 1 byte per cycle while
// the queue has room; the executor drains one command a cycle unless stalled.
// Reset: synchronous on aresetn low; parser, column, queue and output valid
// clear, both size registers return to 0. No clearing pass.
// ----------------------------------------------------------------------------
module pgs_rle_span_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [prsd_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [prsd_pkg::CFG_W-1:0]     cfg_wdata,
    // coded byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rle_byte
    input  logic                           s_tlast,   // end_of_data
    // span output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] color_index, [23:8] start_column, [39:24] row_number,
    // [53:40] span_length, [55:54] zero
    output logic [prsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // line_end
    output logic                           m_tuser    // image_done
);
    import prsd_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic byte_accept;
    logic cmd_push;
    logic cmd_pop;
    logic fifo_full;
    logic fifo_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata;
            end else if (cfg_addr == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    assign s_tready    = !fifo_full;
    assign byte_accept = s_tvalid && s_tready;

    // byte parser
    prsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rle_byte     (s_tdata),
        .end_of_data  (s_tlast),
        .image_height (height_reg),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    // command queue
    prsd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_cmd  (front_cmd),
        .pop       (cmd_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_cmd  (head_cmd)
    );

    // span executor
    prsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .image_width (width_reg),
        .cmd_valid   (fifo_not_empty),
        .cmd         (head_cmd),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== rtl/core/prsd_checker.sv =====
// ----------------------------------------------------------------------------
// prsd_checker
// Port-level checks on the span decoder's result words.
// ----------------------------------------------------------------------------
module prsd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [prsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import prsd_pkg::*;

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // end-of-line marks carry no colour, column or length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[23:0] == 24'd0) && (m_tdata[55:40] == 16'd0))
        else $error("end-of-line mark with span payload");

    // spans always write at least one pixel and never flag image done
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[53:40] != 14'd0) && !m_tuser)
        else $error("empty span or span flagged as image done");

    // padding bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:54] == 2'b00)
        else $error("nonzero padding in result word");

endmodule

bind pgs_rle_span_decoder prsd_checker u_prsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== verif/pgs_rle_span_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// pgs_rle_span_decoder_tb
// Self-checking bench for the subtitle span decoder. Coded bytes go in on the
// s_ stream and spans and end-of-line marks come back on the m_ stream. A
// behavioral decoder inside the bench follows every accepted byte and queues
// the span it should produce. Each returned word is checked against the
// oldest queued span. A short table of hand-picked bytes comes first. Random
// objects follow under several image sizes, with random gaps on both sides.
// ----------------------------------------------------------------------------
module pgs_rle_span_decoder_tb;
    import prsd_pkg::*;

    // one span or end-of-line mark, as the decoder reports it
    typedef struct packed {
        logic [7:0]  color;
        logic [15:0] col;
        logic [15:0] row;
        logic [13:0] len;
        logic        line_end;
        logic        done;
    } span_t;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] b;
        logic       eod;
        logic       typed;
        logic       has;
        span_t      want;
    } dir_row_t;

    // where the byte parser stands inside a code
    typedef enum logic [1:0] {
        WAIT_CODE,
        WAIT_FLAGS,
        WAIT_LOWLEN,
        WAIT_COLOR
    } parse_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [ADDR_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // behavioral decoder state and its copy of the size registers
    logic [15:0] img_w = '0;
    logic [15:0] img_h = '0;
    parse_t      dec_phase = WAIT_CODE;
    logic        run_colored = 1'b0;
    logic [13:0] run_len = '0;
    logic [15:0] cur_col = '0;
    logic [15:0] cur_row = '0;
    logic        img_done = 1'b0;

    span_t    pending_spans[$];
    dir_row_t vectors[$];
    int       errors = 0;
    int       sent_bytes = 0;
    logic     calm = 1'b0;

    pgs_rle_span_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // paint up to want pixels at the current column, clipped to the width
    function automatic logic emit_run(input int unsigned want, input logic [7:0] c,
                                      output span_t s);
        int unsigned room;
        int unsigned n;
        room = (cur_col < img_w) ? int'(img_w) - int'(cur_col) : 0;
        n = (want < room) ? want : room;
        s = '0;
        if (n == 0) return 1'b0;
        s.color = c;
        s.col   = cur_col;
        s.row   = cur_row;
        s.len   = n[13:0];
        cur_col = cur_col + n[15:0];
        return 1'b1;
    endfunction

    // advance the decoder by one byte; returns 1 when a word is due
    function automatic logic decode_byte(input logic [7:0] b, input logic eod,
                                         output span_t s);
        logic got;
        got = 1'b0;
        s = '0;
        if (!img_done && cur_row < img_h) begin
            case (dec_phase)
                WAIT_CODE: begin
                    if (b != BYTE_ESCAPE) got = emit_run(1, b, s);
                    else dec_phase = WAIT_FLAGS;
                end
                WAIT_FLAGS: begin
                    dec_phase = WAIT_CODE;
                    if (b == BYTE_ESCAPE) begin
                        // end of line: mark carries the row that ended
                        s.row      = cur_row;
                        s.line_end = 1'b1;
                        cur_col    = '0;
                        cur_row    = cur_row + 16'd1;
                        if (cur_row >= img_h) img_done = 1'b1;
                        s.done     = img_done;
                        got        = 1'b1;
                    end else begin
                        case (b[7:6])
                            RUN_SHORT_CLEAR: got = emit_run(32'(b[5:0]), 8'h00, s);
                            RUN_LONG_CLEAR: begin
                                run_len     = {b[5:0], 8'h00};
                                run_colored = 1'b0;
                                dec_phase   = WAIT_LOWLEN;
                            end
                            RUN_SHORT_COLOR: begin
                                run_len     = {8'h00, b[5:0]};
                                run_colored = 1'b1;
                                dec_phase   = WAIT_COLOR;
                            end
                            default: begin
                                run_len     = {b[5:0], 8'h00};
                                run_colored = 1'b1;
                                dec_phase   = WAIT_LOWLEN;
                            end
                        endcase
                    end
                end
                WAIT_LOWLEN: begin
                    run_len = run_len | {6'h00, b};
                    if (run_colored) begin
                        dec_phase = WAIT_COLOR;
                    end else begin
                        dec_phase = WAIT_CODE;
                        got = emit_run(32'(run_len), 8'h00, s);
                    end
                end
                default: begin
                    dec_phase = WAIT_CODE;
                    got = emit_run(32'(run_len), b, s);
                end
            endcase
        end
        // end of object drops any open code and starts over
        if (eod) begin
            dec_phase   = WAIT_CODE;
            run_colored = 1'b0;
            run_len     = '0;
            cur_col     = '0;
            cur_row     = '0;
            img_done    = 1'b0;
        end
        return got;
    endfunction

    function automatic span_t mk_span(input logic [7:0] c, input logic [15:0] col,
                                      input logic [15:0] r, input logic [13:0] n,
                                      input logic le, input logic dn);
        span_t s;
        s = '{color: c, col: col, row: r, len: n, line_end: le, done: dn};
        return s;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic eod);
        vectors.push_back('{b: b, eod: eod, typed: 1'b0, has: 1'b0, want: '0});
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic eod,
                                      input logic has, input span_t want);
        vectors.push_back('{b: b, eod: eod, typed: 1'b1, has: has, want: want});
    endfunction

    // offer one word with random gaps ahead of it, then queue its span
    task automatic put_byte(input logic [7:0] b, input logic eod, input logic typed,
                            input logic t_has, input span_t t_span);
        span_t sp;
        logic  has;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        do @(posedge aclk); while (!s_tready);
        has = decode_byte(b, eod, sp);
        sent_bytes++;
        if (typed) begin
            has = t_has;
            sp  = t_span;
        end
        if (has) pending_spans.push_back(sp);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eod);
        put_byte(b, eod, 1'b0, 1'b0, '0);
    endtask

    task automatic run_table();
        dir_row_t r;
        while (vectors.size() != 0) begin
            r = vectors.pop_front();
            put_byte(r.b, r.eod, r.typed, r.has, r.want);
        end
    endtask

    // hold the sender until every queued span has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_spans.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_IMAGE_WIDTH) img_w = val;
        else if (idx == REG_IMAGE_HEIGHT) img_h = val;
    endtask

    // new image size, written only once the block has gone quiet
    task automatic set_size(input logic [15:0] w, input logic [15:0] h);
        drain();
        repeat (8) @(posedge aclk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        // a write past the last register must change nothing
        write_reg(REG_IMAGE_HEIGHT + ADDR_W'($urandom_range(1, 254)), CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // one well-formed code with random content
    task automatic send_code(input logic last_one);
        int unsigned roll;
        logic [5:0]  len6;
        logic [7:0]  lo;
        logic [7:0]  colr;
        roll = $urandom_range(99);
        len6 = 6'($urandom_range(63));
        lo   = 8'($urandom);
        colr = 8'($urandom);
        if ($urandom_range(9) == 0) begin
            len6 = '0;
            lo   = '0;
        end
        if (roll < 30) begin
            send_byte(8'($urandom_range(1, 255)), last_one);
        end else if (roll < 82) begin
            send_byte(BYTE_ESCAPE, 1'b0);
            if (roll < 45) begin
                send_byte({RUN_SHORT_CLEAR, len6}, last_one);
            end else if (roll < 60) begin
                send_byte({RUN_SHORT_COLOR, len6}, 1'b0);
                send_byte(colr, last_one);
            end else if (roll < 70) begin
                send_byte({RUN_LONG_CLEAR, len6}, 1'b0);
                send_byte(lo, last_one);
            end else begin
                send_byte({RUN_LONG_COLOR, len6}, 1'b0);
                send_byte(lo, 1'b0);
                send_byte(colr, last_one);
            end
        end else begin
            send_byte(BYTE_ESCAPE, 1'b0);
            send_byte(BYTE_ESCAPE, last_one);
        end
    endtask

    // mostly whole objects, some loose bytes and broken codes
    task automatic random_phase(input int n);
        int   goal;
        int   n_codes;
        logic paused;
        goal   = sent_bytes + n;
        paused = 1'b0;
        while (sent_bytes < goal) begin
            if (!paused && sent_bytes > goal - n / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                n_codes = $urandom_range(1, (img_h < 4) ? 8 : 30);
                for (int k = 0; k < n_codes; k++) send_code(k == n_codes - 1);
            end else begin
                n_codes = $urandom_range(1, 6);
                for (int k = 0; k < n_codes; k++)
                    send_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    // result side: random back-pressure and check against the oldest span
    always @(posedge aclk) begin : rx_side
        span_t seen;
        span_t want;
        seen = '{color: m_tdata[7:0], col: m_tdata[23:8], row: m_tdata[39:24],
                 len: m_tdata[53:40], line_end: m_tlast, done: m_tuser};
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spans.size() == 0) begin
                if (errors < 10) begin
                    $write("unexpected word at %0t: c=%h col=%0d row=%0d len=%0d",
                           $time, seen.color, seen.col, seen.row, seen.len);
                    $display(" eol=%b done=%b", seen.line_end, seen.done);
                end
                errors++;
            end else begin
                want = pending_spans.pop_front();
                if (seen.color !== want.color || seen.col !== want.col ||
                    seen.row !== want.row || seen.len !== want.len ||
                    seen.line_end !== want.line_end || seen.done !== want.done ||
                    m_tdata[55:54] !== 2'b00) begin
                    if (errors < 10) begin
                        $write("mismatch at %0t: want c=%h col=%0d row=%0d len=%0d",
                               $time, want.color, want.col, want.row, want.len);
                        $write(" eol=%b done=%b, got c=%h col=%0d row=%0d len=%0d",
                               want.line_end, want.done, seen.color, seen.col,
                               seen.row, seen.len);
                        $display(" eol=%b done=%b pad=%b", seen.line_end, seen.done,
                                 m_tdata[55:54]);
                    end
                    errors++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 26);
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // size registers still zero after reset: every byte is ignored
        add_typed(8'h2C, 1'b0, 1'b0, '0);
        add_typed(8'h00, 1'b1, 1'b0, '0);
        run_table();

        set_size(16'd10, 16'd2);
        // single pixel
        add_typed(8'h07, 1'b0, 1'b1, mk_span(8'h07, 16'd0, 16'd0, 14'd1, 1'b0, 1'b0));
        // short transparent run
        add_row(8'h00, 1'b0);
        add_row(8'h05, 1'b0);
        // short coloured run clipped at the right edge
        add_row(8'h00, 1'b0);
        add_row(8'h86, 1'b0);
        add_row(8'hFF, 1'b0);
        // pixel with the column already at the width
        add_typed(8'h01, 1'b0, 1'b0, '0);
        // end of line
        add_row(8'h00, 1'b0);
        add_typed(8'h00, 1'b0, 1'b1, mk_span(8'h00, 16'd0, 16'd0, 14'd0, 1'b1, 1'b0));
        // long transparent run of length zero
        add_row(8'h00, 1'b0);
        add_row(8'h40, 1'b0);
        add_typed(8'h00, 1'b0, 1'b0, '0);
        // long coloured run
        add_row(8'h00, 1'b0);
        add_row(8'hC0, 1'b0);
        add_row(8'h03, 1'b0);
        add_row(8'h11, 1'b0);
        // longest transparent run, clipped to the rest of the line
        add_row(8'h00, 1'b0);
        add_row(8'h7F, 1'b0);
        add_typed(8'hFF, 1'b0, 1'b1, mk_span(8'h00, 16'd3, 16'd1, 14'd7, 1'b0, 1'b0));
        // last line ends the image
        add_row(8'h00, 1'b0);
        add_typed(8'h00, 1'b0, 1'b1, mk_span(8'h00, 16'd0, 16'd1, 14'd0, 1'b1, 1'b1));
        // past the last row: ignored, then end of data
        add_typed(8'h09, 1'b1, 1'b0, '0);
        // open code dropped by end of data
        add_row(8'h00, 1'b0);
        add_typed(8'hC1, 1'b1, 1'b0, '0);
        // fresh object starts at the origin
        add_typed(8'h05, 1'b1, 1'b1, mk_span(8'h05, 16'd0, 16'd0, 14'd1, 1'b0, 1'b0));
        run_table();

        // random objects under several sizes
        set_size(16'd12, 16'd4);
        random_phase(270);
        set_size(16'd0, 16'd6);
        random_phase(270);
        calm = 1'b1;
        set_size(16'hFFFF, 16'hFFFF);
        random_phase(270);
        calm = 1'b0;
        set_size(16'd1, 16'd1);
        random_phase(260);
        set_size(16'($urandom_range(2, 40)), 16'($urandom_range(1, 10)));
        random_phase(270);
        set_size(16'hFFFF, 16'd3);
        random_phase(260);

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
